// File: rtl/mprg_pkg.sv
// mprg_pkg: shared types, constants and small modular-reduction helpers
// for the mixing pseudo-random generator; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package mprg_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned HALF_W   = 16;
	localparam int unsigned TBL_N    = 7;
	localparam int unsigned TBL_IW   = 3;
	localparam int unsigned STEP_W   = 6;
	localparam int unsigned CNT_W    = 8;

	// reciprocal unit widths: multiplier constant, product, back-multiply
	localparam int unsigned RCP_W    = HALF_W + 1;
	localparam int unsigned PROD_W   = HALF_W + RCP_W;
	localparam int unsigned BACK_W   = HALF_W + CNT_W;

	// divider step count
	localparam logic [STEP_W-1:0] STEPS_WORD = STEP_W'(WORD_W);

	// phase wheels: mix by phase mod 3, table entry by phase mod 7
	localparam logic [1:0] MIX_ADD  = 2'd0;
	localparam logic [1:0] MIX_SUB  = 2'd1;
	localparam logic [1:0] MIX_SWAP = 2'd2;
	localparam logic [1:0] MIX_LAST = MIX_SWAP;
	localparam logic [TBL_IW-1:0] TBL_LAST = TBL_IW'(TBL_N - 1);

	typedef logic [WORD_W-1:0] word_t;

	typedef word_t tbl_t [TBL_N];

	localparam tbl_t TBL_INIT = '{
		32'h0000_0055, 32'h0000_00da, 32'h0000_003f, 32'h0000_0012,
		32'h0000_00ea, 32'h0000_007a, 32'h0000_0015
	};

	// load request for the serial remainder unit
	typedef struct packed {
		logic              load;
		word_t             num;
		word_t             den;
		logic [STEP_W-1:0] steps;
	} div_load_t;

	// 16-bit value mod 255: 256 is 1 mod 255, so add the two bytes and fold
	function automatic logic [7:0] mod255(input logic [HALF_W-1:0] v);
		logic [8:0] s;
		begin
			s = {1'b0, v[15:8]} + {1'b0, v[7:0]};
			if (s >= 9'd255) begin
				s = s - 9'd255;
			end
			if (s >= 9'd255) begin
				s = s - 9'd255;
			end
			return s[7:0];
		end
	endfunction

	// 8-bit value mod 7: 8 is 1 mod 7, so add the octal digits and fold
	function automatic logic [TBL_IW-1:0] mod7(input logic [CNT_W-1:0] v);
		logic [4:0] s;
		begin
			s = {2'b00, v[2:0]} + {2'b00, v[5:3]} + {3'b000, v[7:6]};
			if (s >= 5'd7) begin
				s = s - 5'd7;
			end
			if (s >= 5'd7) begin
				s = s - 5'd7;
			end
			return s[TBL_IW-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/mixing_pseudo_random_generator.sv
// Mixing pseudo-random word generator: valid/stall draw channel, result
// channel and an APB-style seed register. Depends on mprg_pkg.
// Usage:
//   Each item on the input channel (in_valid, in_stall, clip) is one draw,
//   answered by one item (raw_word, clipped_value) on the output channel
//   (out_valid, out_stall); clipped_value is raw_word mod clip, or raw_word
//   itself when clip is zero.
//   After accept a draw passes BUMP when the bump countdown runs out, then
//   RESH when the reshuffle countdown runs out or MIX otherwise, then WORD,
//   CLIP for a nonzero clip (a bit-serial remainder unit, 32 steps) and FIN;
//   the bump and reshuffle reductions by constant periods use a reciprocal
//   multiply with a registered quotient. in_stall is high from accept until
//   the result reaches the output register, and in the cycle of a seed write,
//   so a new draw is accepted only after the last result has reached it.
//   The output register holds a finished item while out_stall is high; the
//   next draw is accepted and worked on meanwhile and waits for it to free.
//   Reset loads seed 0, the start word, the countdowns and the adder table.
//   Writing the seed register (byte address 0) reloads the word, clears both
//   phase wheels and reloads both countdowns; the table keeps its contents.
//   Write it only while no draw is in flight.
`timescale 1ns / 1ps
`default_nettype none

module mixing_pseudo_random_generator #(
	parameter int unsigned FIRST_RESHUFFLE_DELAY = 32,
	parameter int unsigned BUMP_PERIOD           = 64,
	parameter int unsigned RESHUFFLE_MODULUS     = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// draw requests
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] clip,
	// results
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      raw_word,
	output logic [31:0]      clipped_value,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic [mprg_pkg::CNT_W-1:0] RESH_RELOAD =
		mprg_pkg::CNT_W'(FIRST_RESHUFFLE_DELAY);
	localparam logic [mprg_pkg::CNT_W-1:0] BUMP_RELOAD =
		mprg_pkg::CNT_W'(BUMP_PERIOD);
	localparam logic [1:0] ADDR_SEED = 2'd0;

	// reciprocal constants: quotient = (n * M) >> SH, exact for 16-bit n
	localparam int unsigned BUMP_SH = mprg_pkg::HALF_W + $clog2(BUMP_PERIOD);
	localparam int unsigned RESH_SH = mprg_pkg::HALF_W + $clog2(RESHUFFLE_MODULUS);
	localparam logic [mprg_pkg::RCP_W-1:0] BUMP_M = mprg_pkg::RCP_W'(
		((64'd1 << BUMP_SH) + 64'(BUMP_PERIOD) - 64'd1) / 64'(BUMP_PERIOD));
	localparam logic [mprg_pkg::RCP_W-1:0] RESH_M = mprg_pkg::RCP_W'(
		((64'd1 << RESH_SH) + 64'(RESHUFFLE_MODULUS) - 64'd1) / 64'(RESHUFFLE_MODULUS));
	localparam logic [mprg_pkg::CNT_W-1:0] BUMP_DEN = mprg_pkg::CNT_W'(BUMP_PERIOD);
	localparam logic [mprg_pkg::CNT_W-1:0] RESH_DEN = mprg_pkg::CNT_W'(RESHUFFLE_MODULUS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUMP,
		ST_RESH,
		ST_MIX,
		ST_WORD,
		ST_CLIP,
		ST_FIN
	} state_t;

	state_t state_q;

	mprg_pkg::word_t seed_q;
	mprg_pkg::word_t cur_word_q;
	mprg_pkg::word_t hi_q;
	mprg_pkg::word_t lo_q;
	mprg_pkg::word_t clip_q;
	mprg_pkg::word_t word_q;
	mprg_pkg::word_t result_q;
	mprg_pkg::word_t raw_word_q;
	mprg_pkg::word_t clipped_q;
	logic            out_valid_q;
	logic            resh_fire_q;
	logic [1:0]                    mix_ph_q;
	logic [mprg_pkg::TBL_IW-1:0]   tbl_ph_q;
	logic [mprg_pkg::CNT_W-1:0]    resh_cnt_q;
	logic [mprg_pkg::CNT_W-1:0]    bump_cnt_q;
	mprg_pkg::tbl_t                tbl_q;

	// bit-serial remainder unit
	mprg_pkg::div_load_t           div_ld;
	mprg_pkg::word_t               div_rem_q;
	mprg_pkg::word_t               div_num_q;
	mprg_pkg::word_t               div_den_q;
	logic [mprg_pkg::STEP_W-1:0]   div_cnt_q;
	logic [mprg_pkg::WORD_W:0]     div_trial;
	mprg_pkg::word_t               div_rem_next;
	logic                          div_done;

	// reciprocal unit for the half-word reductions
	logic                          rcp_bump;
	logic [mprg_pkg::HALF_W-1:0]   rcp_num;
	logic [mprg_pkg::PROD_W-1:0]   rcp_prod;
	logic [mprg_pkg::HALF_W-1:0]   rcp_quo;
	logic [mprg_pkg::HALF_W-1:0]   rcp_quo_q;
	logic [mprg_pkg::BACK_W-1:0]   rcp_back;
	logic [mprg_pkg::CNT_W-1:0]    rcp_rem;
	logic                          rcp_half_q;
	logic                          rcp_done;

	logic            in_acc;
	logic            cfg_wr;
	logic            bump_fire;
	logic            resh_fire;
	mprg_pkg::word_t tbl_rd;
	mprg_pkg::word_t word_next;
	mprg_pkg::word_t hi_diff;
	logic [mprg_pkg::CNT_W-1:0] k_val;

	// handshakes
	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE) || cfg_wr;
	assign cfg_wr    = psel && penable && pwrite && pready && (paddr == ADDR_SEED);
	assign pready    = 1'b1;
	assign prdata    = seed_q;

	assign out_valid     = out_valid_q;
	assign raw_word      = raw_word_q;
	assign clipped_value = clipped_q;

	// countdown checks and table read
	assign bump_fire = (bump_cnt_q <= mprg_pkg::CNT_W'(1));
	assign resh_fire = (resh_cnt_q <= mprg_pkg::CNT_W'(1));
	assign tbl_rd    = tbl_q[tbl_ph_q];
	assign hi_diff   = hi_q - lo_q;
	assign k_val     = rcp_rem;
	assign word_next = {lo_q[mprg_pkg::HALF_W-1:0], {mprg_pkg::HALF_W{1'b0}}} | hi_q;

	// one restoring step of the remainder unit
	assign div_trial    = {div_rem_q, div_num_q[mprg_pkg::WORD_W-1]};
	assign div_rem_next = (div_trial >= {1'b0, div_den_q}) ?
		mprg_pkg::WORD_W'(div_trial - {1'b0, div_den_q}) :
		div_trial[mprg_pkg::WORD_W-1:0];
	assign div_done     = (div_cnt_q == mprg_pkg::STEP_W'(1));

	// reciprocal reduction: quotient registered first, remainder from the registered quotient
	assign rcp_bump = (state_q == ST_BUMP);
	assign rcp_num  = rcp_bump ? hi_q[mprg_pkg::HALF_W-1:0] : lo_q[mprg_pkg::HALF_W-1:0];
	assign rcp_prod = mprg_pkg::PROD_W'(rcp_num) *
		(rcp_bump ? mprg_pkg::PROD_W'(BUMP_M) : mprg_pkg::PROD_W'(RESH_M));
	assign rcp_quo  = rcp_bump ? mprg_pkg::HALF_W'(rcp_prod >> BUMP_SH) :
		mprg_pkg::HALF_W'(rcp_prod >> RESH_SH);
	assign rcp_back = mprg_pkg::BACK_W'(rcp_quo_q) *
		mprg_pkg::BACK_W'(rcp_bump ? BUMP_DEN : RESH_DEN);
	assign rcp_rem  = mprg_pkg::CNT_W'(mprg_pkg::BACK_W'(rcp_num) - rcp_back);
	assign rcp_done = rcp_half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcp_half_q <= 1'b0;
		end else if (rcp_bump || (state_q == ST_RESH)) begin
			rcp_half_q <= !rcp_half_q;
		end
	end

	always_ff @(posedge clk) begin
		rcp_quo_q <= rcp_quo;
	end

	// requests to the remainder unit
	always_comb begin
		div_ld = '0;
		case (state_q)
			ST_WORD: begin
				if (clip_q != '0) begin
					div_ld.load  = 1'b1;
					div_ld.num   = word_next;
					div_ld.den   = clip_q;
					div_ld.steps = mprg_pkg::STEPS_WORD;
				end
			end
			default: begin
				div_ld = '0;
			end
		endcase
	end

	// remainder unit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_ld.load) begin
			div_cnt_q <= div_ld.steps;
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - mprg_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_ld.load) begin
			div_rem_q <= '0;
			div_num_q <= div_ld.num;
			div_den_q <= div_ld.den;
		end else if (div_cnt_q != '0) begin
			div_rem_q <= div_rem_next;
			div_num_q <= {div_num_q[mprg_pkg::WORD_W-2:0], 1'b0};
		end
	end

	// draw sequencer, generator state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= '0;
			cur_word_q  <= '0;
			mix_ph_q    <= '0;
			tbl_ph_q    <= '0;
			resh_cnt_q  <= RESH_RELOAD;
			bump_cnt_q  <= BUMP_RELOAD;
			tbl_q       <= mprg_pkg::TBL_INIT;
			resh_fire_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output register drains
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cfg_wr) begin
						seed_q     <= pwdata;
						cur_word_q <= pwdata;
						mix_ph_q   <= '0;
						tbl_ph_q   <= '0;
						resh_cnt_q <= RESH_RELOAD;
						bump_cnt_q <= BUMP_RELOAD;
					end else if (in_acc) begin
						clip_q      <= clip;
						hi_q        <= {16'h0000, cur_word_q[31:16]};
						lo_q        <= {16'h0000, cur_word_q[15:0]};
						resh_fire_q <= resh_fire;
						if (bump_fire) begin
							state_q <= ST_BUMP;
						end else begin
							bump_cnt_q <= bump_cnt_q - mprg_pkg::CNT_W'(1);
							state_q    <= resh_fire ? ST_RESH : ST_MIX;
						end
					end
				end
				ST_BUMP: begin
					// countdown reload from hi mod period, whole table gains one
					if (rcp_done) begin
						bump_cnt_q <= rcp_rem;
						for (int i = 0; i < int'(mprg_pkg::TBL_N); i++) begin
							tbl_q[i] <= tbl_q[i] + 32'd1;
						end
						state_q <= resh_fire_q ? ST_RESH : ST_MIX;
					end
				end
				ST_RESH: begin
					// overwrite one entry and cross-subtract the halves
					if (rcp_done) begin
						resh_cnt_q             <= k_val;
						tbl_q[mprg_pkg::mod7(k_val)] <=
							{24'h000000, mprg_pkg::mod255(hi_q[15:0])};
						hi_q    <= hi_diff;
						lo_q    <= lo_q - hi_diff;
						state_q <= ST_WORD;
					end
				end
				ST_MIX: begin
					resh_cnt_q <= resh_cnt_q - mprg_pkg::CNT_W'(1);
					case (mix_ph_q)
						mprg_pkg::MIX_ADD: begin
							lo_q <= lo_q + tbl_rd;
						end
						mprg_pkg::MIX_SUB: begin
							lo_q <= lo_q - tbl_rd;
							hi_q <= hi_q - tbl_rd;
						end
						default: begin
							lo_q <= {16'h0000, lo_q[7:0], lo_q[15:8]};
						end
					endcase
					state_q <= ST_WORD;
				end
				ST_WORD: begin
					// new word; phase wheels advance
					cur_word_q <= word_next;
					word_q     <= word_next;
					mix_ph_q   <= (mix_ph_q == mprg_pkg::MIX_LAST) ? '0 :
						mix_ph_q + 2'd1;
					tbl_ph_q   <= (tbl_ph_q == mprg_pkg::TBL_LAST) ? '0 :
						tbl_ph_q + mprg_pkg::TBL_IW'(1);
					if (clip_q == '0) begin
						result_q <= word_next;
						state_q  <= ST_FIN;
					end else begin
						state_q <= ST_CLIP;
					end
				end
				ST_CLIP: begin
					if (div_done) begin
						result_q <= div_rem_next;
						state_q  <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hand over once the output register is free
					if (!out_valid_q || !out_stall) begin
						raw_word_q  <= word_q;
						clipped_q   <= result_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
